[rtl/priority_ready_queue_scheduler_assert.svh]
// Assertion helpers shared by the scheduler RTL.
// Both macros sample on aclk and stay quiet while aresetn is low.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Same-cycle implication.
`define PRQS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PRQS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/prqs_pkg.sv]
package prqs_pkg;

    localparam int KIND_W   = 3;
    localparam int ID_W     = 6;
    localparam int PRIO_W   = 3;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    localparam int DEF_LEVELS = 8;
    localparam int DEF_SLOTS  = 64;

    typedef enum logic [KIND_W-1:0] {
        KIND_CREATE  = 3'd0,
        KIND_RESUME  = 3'd1,
        KIND_PICK    = 3'd2,
        KIND_YIELD   = 3'd3,
        KIND_DESTROY = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        SLOT_FREE     = 2'd0,
        SLOT_SUSP     = 2'd1,
        SLOT_RUNNABLE = 2'd2,
        SLOT_RUNNING  = 2'd3
    } slot_st_t;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD_STATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;

    // Update command for the per-level head/tail table.
    typedef struct packed {
        logic set_head;
        logic set_tail;
        logic set_ne;
        logic clr_ne;
    } lvl_upd_t;

endpackage

[rtl/priority_ready_queue_scheduler.sv]
// Ready-queue scheduler with one FIFO of thread slots per priority level.
// Input channel s_*: one transaction carries a command (create, resume,
// pick, yield, destroy) with a thread id and, for create, a priority.
// Result channel m_*: exactly one result transaction per command, in order,
// carrying a status code and the thread chosen by a successful pick.
// A command is accepted in the idle state, which issues the synchronous
// slot/link memory read; the execute state does the read-modify-write of
// memories and level table. A new command is taken only after the last one
// has left the execute state; its result goes to the output register, or
// to the hold register while the receiver stalls. After aresetn is released,
// a clearing pass frees every slot; s_tready stays low in reset and that pass.
// A two-entry result buffer (output register plus a hold register) lets
// the block take one more command while a result waits on a stalled
// receiver; with both entries full, s_tready drops until m_tready returns.
`include "priority_ready_queue_scheduler_assert.svh"

module priority_ready_queue_scheduler
    import prqs_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS,
    parameter int SLOTS  = DEF_SLOTS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [2:0] kind, [8:3] thread_id, [11:9] priority_req, [15:12] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [7:2] picked_thread
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SW_W   = 2 + LVL_W;
    localparam int RES_W  = STATUS_W + ID_W;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t               state_reg, state_next;
    logic                 clr_active_reg, clr_active_next;
    logic [SLOT_W-1:0]    clr_idx_reg, clr_idx_next;
    kind_t                kind_reg, kind_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [PRIO_W-1:0]    prio_reg, prio_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [RES_W-1:0]     m_data_reg, m_data_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [RES_W-1:0]     hold_data_reg, hold_data_next;

    // Slot memory: {state, level}; link memory: next slot in a level FIFO.
    logic                 slot_we;
    logic [SLOT_W-1:0]    slot_waddr;
    logic [SW_W-1:0]      slot_wdata;
    logic [SLOT_W-1:0]    slot_raddr;
    logic [SW_W-1:0]      slot_rdata;
    logic                 ex_slot_we;
    logic [SLOT_W-1:0]    ex_slot_waddr;
    logic [SW_W-1:0]      ex_slot_wdata;
    logic                 link_we;
    logic [SLOT_W-1:0]    link_waddr;
    logic [SLOT_W-1:0]    link_wdata;
    logic [SLOT_W-1:0]    link_rdata;

    lvl_upd_t             upd;
    logic [LVL_W-1:0]     upd_lvl;
    logic [SLOT_W-1:0]    upd_head;
    logic [LVL_W-1:0]     sel_lvl;
    logic [SLOT_W-1:0]    sel_head;
    logic [SLOT_W-1:0]    sel_tail;
    logic                 sel_nonempty;
    logic                 top_found;
    logic [LVL_W-1:0]     top_lvl;

    logic                 accept;
    logic [ID_W-1:0]      in_id;
    logic [SLOT_W-1:0]    id_idx;
    logic                 id_ok;
    slot_st_t             rd_st;
    logic [LVL_W-1:0]     rd_lvl;
    logic [LVL_W-1:0]     prio_lvl;
    logic [STATUS_W-1:0]  res_status;
    logic [ID_W-1:0]      res_picked;
    logic                 is_pick;

    assign s_tready = (state_reg == ST_IDLE) && !clr_active_reg && !hold_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    assign in_id   = s_tdata[KIND_W +: ID_W];
    assign id_idx  = SLOT_W'(id_reg);
    assign id_ok   = 32'(id_reg) < 32'(SLOTS);
    assign rd_st   = slot_st_t'(slot_rdata[SW_W-1 -: 2]);
    assign rd_lvl  = slot_rdata[LVL_W-1:0];
    assign is_pick = (kind_reg == KIND_PICK);

    // Saturate the requested priority to the last level (LEVELS-1), the lowest priority.
    assign prio_lvl = (32'(prio_reg) >= 32'(LEVELS)) ? LVL_W'(LEVELS - 1) : LVL_W'(prio_reg);

    // Look at the top level while idle and for pick, else at the slot's own level.
    assign sel_lvl = ((state_reg == ST_IDLE) || is_pick) ? top_lvl : rd_lvl;

    // Issue the reads in the accept cycle: pick needs the head's link.
    assign slot_raddr = SLOT_W'(in_id);

    prqs_ram #(
        .WIDTH (SW_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    prqs_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (sel_head),
        .rdata (link_rdata)
    );

    prqs_lvl_tbl #(
        .LEVELS (LEVELS),
        .SLOTS  (SLOTS)
    ) u_lvl_tbl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .upd          (upd),
        .upd_lvl      (upd_lvl),
        .upd_head     (upd_head),
        .upd_tail     (id_idx),
        .sel_lvl      (sel_lvl),
        .sel_head     (sel_head),
        .sel_tail     (sel_tail),
        .sel_nonempty (sel_nonempty),
        .top_found    (top_found),
        .top_lvl      (top_lvl)
    );

    // Execute cycle: check the slot state and update memories and level table.
    always_comb begin
        ex_slot_we    = 1'b0;
        ex_slot_waddr = id_idx;
        ex_slot_wdata = {SLOT_FREE, rd_lvl};
        link_we       = 1'b0;
        link_waddr    = sel_tail;
        link_wdata    = id_idx;
        upd           = '0;
        upd_lvl       = sel_lvl;
        upd_head      = id_idx;
        res_status    = STATUS_OK;
        res_picked    = '0;
        if (state_reg == ST_EXEC) begin
            case (kind_reg)
                KIND_CREATE: begin
                    if (id_ok && (rd_st == SLOT_FREE)) begin
                        ex_slot_we    = 1'b1;
                        ex_slot_wdata = {SLOT_SUSP, prio_lvl};
                    end else begin
                        res_status = STATUS_BAD_STATE;
                    end
                end
                KIND_RESUME, KIND_YIELD: begin
                    if (id_ok && (((kind_reg == KIND_RESUME) && (rd_st == SLOT_SUSP)) ||
                                  ((kind_reg == KIND_YIELD) && (rd_st == SLOT_RUNNING)))) begin
                        // Append at the back of the slot's level.
                        ex_slot_we    = 1'b1;
                        ex_slot_wdata = {SLOT_RUNNABLE, rd_lvl};
                        upd.set_tail  = 1'b1;
                        if (sel_nonempty) begin
                            link_we = 1'b1;
                        end else begin
                            upd.set_head = 1'b1;
                            upd.set_ne   = 1'b1;
                        end
                    end else begin
                        res_status = STATUS_BAD_STATE;
                    end
                end
                KIND_PICK: begin
                    if (top_found) begin
                        // Pop the front; the last entry just empties the level.
                        ex_slot_we    = 1'b1;
                        ex_slot_waddr = sel_head;
                        ex_slot_wdata = {SLOT_RUNNING, top_lvl};
                        upd_head      = link_rdata;
                        if (sel_head == sel_tail) begin
                            upd.clr_ne = 1'b1;
                        end else begin
                            upd.set_head = 1'b1;
                        end
                        res_picked = ID_W'(sel_head);
                    end else begin
                        res_status = STATUS_EMPTY;
                    end
                end
                KIND_DESTROY: begin
                    if (id_ok && (rd_st == SLOT_RUNNING)) begin
                        ex_slot_we = 1'b1;
                    end else begin
                        res_status = STATUS_BAD_STATE;
                    end
                end
                default: begin
                    res_status = STATUS_OK;
                end
            endcase
        end
    end

    // The clearing pass owns the slot write port until it ends.
    always_comb begin
        if (clr_active_reg) begin
            slot_we    = 1'b1;
            slot_waddr = clr_idx_reg;
            slot_wdata = {SLOT_FREE, {LVL_W{1'b0}}};
        end else begin
            slot_we    = ex_slot_we;
            slot_waddr = ex_slot_waddr;
            slot_wdata = ex_slot_wdata;
        end
    end

    always_comb begin
        state_next      = state_reg;
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        prio_next       = prio_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_data_next     = m_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_data_next  = hold_data_reg;

        if (clr_active_reg) begin
            clr_idx_next = clr_idx_reg + 1'b1;
            if (clr_idx_reg == SLOT_W'(SLOTS - 1)) begin
                clr_active_next = 1'b0;
            end
        end

        // Drain the output register, refilling it from the hold register.
        if (m_tvalid_reg && m_tready) begin
            if (hold_valid_reg) begin
                m_data_next     = hold_data_reg;
                hold_valid_next = 1'b0;
            end else begin
                m_tvalid_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    kind_next  = kind_t'(s_tdata[KIND_W-1:0]);
                    id_next    = in_id;
                    prio_next  = s_tdata[KIND_W+ID_W +: PRIO_W];
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // Hold is empty here: a command enters only with hold empty.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_data_next   = {res_picked, res_status};
                end else begin
                    hold_valid_next = 1'b1;
                    hold_data_next  = {res_picked, res_status};
                end
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
            m_tvalid_reg   <= m_tvalid_next;
            hold_valid_reg <= hold_valid_next;
        end
        kind_reg      <= kind_next;
        id_reg        <= id_next;
        prio_reg      <= prio_next;
        m_data_reg    <= m_data_next;
        hold_data_reg <= hold_data_next;
    end

    `PRQS_ASSERT_IMPL(a_hold_behind_out, hold_valid_reg, m_tvalid_reg, "hold without output")
    `PRQS_ASSERT_IMPL(a_no_accept_in_clear, clr_active_reg, !accept, "accept during clear")
    `PRQS_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == ST_EXEC, "accept without execute")
    `PRQS_ASSERT_NEXT(a_exec_gives_result, state_reg == ST_EXEC, m_tvalid_reg, "missing result")

endmodule

[rtl/prqs_ram.sv]
module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/prqs_lvl_tbl.sv]
module prqs_lvl_tbl
    import prqs_pkg::*;
#(
    parameter int LEVELS = DEF_LEVELS,
    parameter int SLOTS  = DEF_SLOTS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  lvl_upd_t                  upd,
    input  logic [$clog2(LEVELS)-1:0] upd_lvl,
    input  logic [$clog2(SLOTS)-1:0]  upd_head,
    input  logic [$clog2(SLOTS)-1:0]  upd_tail,
    input  logic [$clog2(LEVELS)-1:0] sel_lvl,
    output logic [$clog2(SLOTS)-1:0]  sel_head,
    output logic [$clog2(SLOTS)-1:0]  sel_tail,
    output logic                      sel_nonempty,
    output logic                      top_found,
    output logic [$clog2(LEVELS)-1:0] top_lvl
);

    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOT_W = $clog2(SLOTS);

    logic [SLOT_W-1:0] head_arr [LEVELS];
    logic [SLOT_W-1:0] tail_arr [LEVELS];
    logic [LEVELS-1:0] nonempty_reg;
    logic [LEVELS-1:0] nonempty_next;

    // Highest priority is the lowest level index.
    always_comb begin
        top_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (nonempty_reg[i]) begin
                top_lvl = LVL_W'(i);
            end
        end
    end

    assign top_found    = |nonempty_reg;
    assign sel_head     = head_arr[sel_lvl];
    assign sel_tail     = tail_arr[sel_lvl];
    assign sel_nonempty = nonempty_reg[sel_lvl];

    always_comb begin
        nonempty_next = nonempty_reg;
        if (upd.set_ne) begin
            nonempty_next[upd_lvl] = 1'b1;
        end
        if (upd.clr_ne) begin
            nonempty_next[upd_lvl] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonempty_reg <= '0;
        end else begin
            nonempty_reg <= nonempty_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.set_head) begin
            head_arr[upd_lvl] <= upd_head;
        end
        if (upd.set_tail) begin
            tail_arr[upd_lvl] <= upd_tail;
        end
    end

endmodule

[verif/tb_priority_ready_queue_scheduler.sv]
module tb_priority_ready_queue_scheduler
    import prqs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NLEVELS = DEF_LEVELS;
    localparam int NSLOTS  = DEF_SLOTS;

    // Two copies of the scheduler state: the stimulus generator steers its
    // commands with one, the checker predicts results with the other.
    localparam int GEN_VIEW = 0;
    localparam int CHK_VIEW = 1;

    localparam int RANDOM_ITEMS   = 1030;
    localparam int LONG_HOLD      = 500;  // receiver stall that fills the block up
    localparam int LONG_HOLD_AT   = 300;  // results seen before that stall starts
    localparam int WATCHDOG_LIMIT = 4000; // cycles without any transaction
    localparam int DRAIN_CYCLES   = 30;

    // Command and result as they travel on s_tdata and m_tdata (lowest field last).
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [ID_W-1:0]   id;
        logic [KIND_W-1:0] kind;
    } sched_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]     picked;
        logic [STATUS_W-1:0] status;
    } sched_res_t;

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [2:0] kind, [8:3] thread_id, [11:9] priority_req, [15:12] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [1:0] status, [7:2] picked_thread
    logic [M_TDATA_W-1:0] m_tdata;

    // Scheduler state, one copy per view.
    slot_st_t          slot_state [2][NSLOTS];
    logic [PRIO_W-1:0] slot_prio  [2][NSLOTS];
    logic [ID_W-1:0]   slot_next  [2][NSLOTS];
    logic [ID_W-1:0]   lvl_head   [2][NLEVELS];
    logic [ID_W-1:0]   lvl_tail   [2][NLEVELS];
    logic [NLEVELS-1:0] lvl_busy  [2];

    sched_cmd_t pending_cmds[$];
    sched_res_t expected_results[$];
    sched_cmd_t cur_cmd;

    int mismatches    = 0;
    int cmds_accepted = 0;
    int results_seen  = 0;
    int send_gap      = 0;
    int recv_gap      = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    int quiet_cycles  = 0;

    priority_ready_queue_scheduler #(
        .LEVELS (NLEVELS),
        .SLOTS  (NSLOTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Append a slot at the back of its level's FIFO and mark it runnable.
    function automatic void ready_push(input int v, input logic [ID_W-1:0] id);
        logic [PRIO_W-1:0] l;
        l = slot_prio[v][id];
        if (lvl_busy[v][l])
            slot_next[v][lvl_tail[v][l]] = id;
        else begin
            lvl_head[v][l] = id;
            lvl_busy[v][l] = 1'b1;
        end
        lvl_tail[v][l]    = id;
        slot_state[v][id] = SLOT_RUNNABLE;
    endfunction

    // Apply one command to a view of the scheduler and return its result.
    function automatic sched_res_t sched_step(input int v, input sched_cmd_t c);
        sched_res_t      r;
        int              l;
        bit              found;
        logic [ID_W-1:0] h;
        r.status = STATUS_OK;
        r.picked = '0;
        found    = 1'b0;
        case (c.kind)
            KIND_CREATE: begin
                if (slot_state[v][c.id] != SLOT_FREE)
                    r.status = STATUS_BAD_STATE;
                else begin
                    slot_prio[v][c.id]  = c.prio;
                    slot_state[v][c.id] = SLOT_SUSP;
                end
            end
            KIND_RESUME: begin
                if (slot_state[v][c.id] != SLOT_SUSP)
                    r.status = STATUS_BAD_STATE;
                else
                    ready_push(v, c.id);
            end
            KIND_PICK: begin
                for (l = 0; l < NLEVELS && !found; l++) begin
                    if (lvl_busy[v][l]) begin
                        found = 1'b1;
                        h     = lvl_head[v][l];
                        if (h == lvl_tail[v][l])
                            lvl_busy[v][l] = 1'b0;
                        else
                            lvl_head[v][l] = slot_next[v][h];
                        slot_state[v][h] = SLOT_RUNNING;
                        r.picked         = h;
                    end
                end
                if (!found)
                    r.status = STATUS_EMPTY;
            end
            KIND_YIELD: begin
                if (slot_state[v][c.id] != SLOT_RUNNING)
                    r.status = STATUS_BAD_STATE;
                else
                    ready_push(v, c.id);
            end
            KIND_DESTROY: begin
                if (slot_state[v][c.id] != SLOT_RUNNING)
                    r.status = STATUS_BAD_STATE;
                else
                    slot_state[v][c.id] = SLOT_FREE;
            end
            default: ; // unused kind codes leave everything alone
        endcase
        return r;
    endfunction

    // Queue a command for the driver and advance the generator's view.
    function automatic void queue_cmd(input logic [KIND_W-1:0] kind,
                                      input logic [ID_W-1:0] id,
                                      input logic [PRIO_W-1:0] prio);
        sched_cmd_t c;
        sched_res_t unused_res;
        c.kind = kind;
        c.id   = id;
        c.prio = prio;
        unused_res = sched_step(GEN_VIEW, c);
        pending_cmds.push_back(c);
    endfunction

    // Pick a random slot that the generator's view holds in the wanted state;
    // fall back to any slot when none is there.
    function automatic logic [ID_W-1:0] slot_in_state(input slot_st_t want);
        int n;
        int k;
        n = 0;
        for (int i = 0; i < NSLOTS; i++)
            if (slot_state[GEN_VIEW][i] == want)
                n++;
        if (n == 0)
            return ID_W'($urandom_range(0, NSLOTS - 1));
        k = $urandom_range(0, n - 1);
        for (int i = 0; i < NSLOTS; i++) begin
            if (slot_state[GEN_VIEW][i] == want) begin
                if (k == 0)
                    return ID_W'(i);
                k--;
            end
        end
        return '0;
    endfunction

    // Draw one random command: mostly lifecycle-correct ones, some raw noise.
    function automatic void queue_random_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 12)
            queue_cmd(KIND_W'($urandom_range(0, 7)), ID_W'($urandom),
                      PRIO_W'($urandom));
        else if (roll < 30)
            queue_cmd(KIND_CREATE, slot_in_state(SLOT_FREE), PRIO_W'($urandom));
        else if (roll < 48)
            queue_cmd(KIND_RESUME, slot_in_state(SLOT_SUSP), PRIO_W'($urandom));
        else if (roll < 72)
            queue_cmd(KIND_PICK, ID_W'($urandom), PRIO_W'($urandom));
        else if (roll < 88)
            queue_cmd(KIND_YIELD, slot_in_state(SLOT_RUNNING), PRIO_W'($urandom));
        else
            queue_cmd(KIND_DESTROY, slot_in_state(SLOT_RUNNING), PRIO_W'($urandom));
    endfunction

    // Idle length between transactions: mostly none or short, a few long,
    // and whole stretches without any idling.
    function automatic int idle_len(input int n);
        int r;
        if ((n / 128) % 4 == 3)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at result %0d: %s", results_seen, what);
        mismatches++;
    endtask

    // Driver: offer pending commands, hold each until the block takes it,
    // and predict the result of every accepted transaction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(sched_step(CHK_VIEW, cur_cmd));
                cmds_accepted++;
                send_gap = idle_len(cmds_accepted);
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() != 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= S_TDATA_W'(cur_cmd);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare every result transaction with the oldest prediction,
    // and drive m_tready with random gaps plus one long hold-off.
    always @(posedge aclk) begin
        sched_res_t got;
        sched_res_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = sched_res_t'(m_tdata);
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  got.status, want.status));
                    if (got.picked !== want.picked)
                        report_mismatch($sformatf("picked_thread %0d, expected %0d",
                                                  got.picked, want.picked));
                end
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && results_seen >= LONG_HOLD_AT) begin
                // Stall long enough for the result buffer to fill and s_tready to drop.
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                    recv_gap = idle_len(results_seen);
            end
        end
    end

    // Watchdog: end the run when no transaction happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        for (int v = 0; v < 2; v++) begin
            for (int i = 0; i < NSLOTS; i++) begin
                slot_state[v][i] = SLOT_FREE;
                slot_prio[v][i]  = '0;
                slot_next[v][i]  = '0;
            end
            for (int l = 0; l < NLEVELS; l++) begin
                lvl_head[v][l] = '0;
                lvl_tail[v][l] = '0;
            end
            lvl_busy[v] = '0;
        end

        // Directed part: empty pick, extreme ids and levels, every wrong-state
        // rejection, FIFO order within a level, and the unused kind codes.
        queue_cmd(KIND_PICK,    6'd0,  3'd0);  // nothing runnable
        queue_cmd(KIND_CREATE,  6'd0,  3'd0);
        queue_cmd(KIND_CREATE,  6'd63, 3'd7);
        queue_cmd(KIND_CREATE,  6'd0,  3'd3);  // slot not free
        queue_cmd(KIND_RESUME,  6'd0,  3'd0);
        queue_cmd(KIND_RESUME,  6'd0,  3'd0);  // already runnable
        queue_cmd(KIND_RESUME,  6'd63, 3'd0);
        queue_cmd(KIND_YIELD,   6'd0,  3'd0);  // not running
        queue_cmd(KIND_DESTROY, 6'd63, 3'd0);  // not running
        queue_cmd(KIND_CREATE,  6'd42, 3'd0);
        queue_cmd(KIND_RESUME,  6'd42, 3'd5);  // priority ignored on resume
        queue_cmd(KIND_PICK,    6'd63, 3'd7);  // takes slot 0
        queue_cmd(KIND_YIELD,   6'd0,  3'd0);  // requeue behind 42
        queue_cmd(KIND_PICK,    6'd0,  3'd0);
        queue_cmd(KIND_PICK,    6'd0,  3'd0);
        queue_cmd(KIND_PICK,    6'd0,  3'd0);  // lowest level last
        queue_cmd(KIND_PICK,    6'd0,  3'd0);  // empty again
        queue_cmd(KIND_DESTROY, 6'd42, 3'd0);
        queue_cmd(KIND_DESTROY, 6'd0,  3'd0);
        for (int k = KIND_DESTROY + 1; k < (1 << KIND_W); k++)
            queue_cmd(KIND_W'(k), 6'd63, 3'd7);
        queue_cmd(KIND_YIELD,   6'd63, 3'd0);
        queue_cmd(KIND_PICK,    6'd0,  3'd0);
        queue_cmd(KIND_DESTROY, 6'd63, 3'd0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
            queue_random_cmd();

        // Hold reset, then release it for good.
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait until every command is taken and every result has come back.
        while (pending_cmds.size() != 0 || s_tvalid)
            @(posedge aclk);
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/prqs_pkg.sv
rtl/prqs_ram.sv
rtl/prqs_lvl_tbl.sv
rtl/priority_ready_queue_scheduler.sv
verif/tb_priority_ready_queue_scheduler.sv
